// ----- rtl/afr_pkg.sv -----
// Package for the API frame receiver: store sizes, host op codes, event codes,
// parser phase codes, frame bytes and the structs passed from parser to top level.
// No dependencies; the parser, top level and checker refer to it by scoped names.
package afr_pkg;

    // Store sizes and the widths that follow from them.
    localparam int FRAME_DEPTH    = 128;
    localparam int RESPONSE_DEPTH = 16;
    localparam int FRAME_AW       = $clog2(FRAME_DEPTH);
    localparam int RESP_AW        = $clog2(RESPONSE_DEPTH);
    localparam int FILL_W         = $clog2(FRAME_DEPTH + 1);
    localparam int RFILL_W        = $clog2(RESPONSE_DEPTH + 1);

    // Host operations carried by each request.
    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_RD_FRAME = 2'd1;
    localparam logic [1:0] OP_RD_RESP  = 2'd2;
    localparam logic [1:0] OP_RELEASE  = 2'd3;

    // Event codes reported with each result.
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_READY  = 3'd1;
    localparam logic [2:0] EV_BADSUM = 3'd2;
    localparam logic [2:0] EV_RESP   = 3'd3;
    localparam logic [2:0] EV_BUSY   = 3'd4;
    localparam logic [2:0] EV_LONG   = 3'd5;

    // Parser phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_RESP   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    // Frame bytes.
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] TYPE_RX64  = 8'h80;
    localparam logic [7:0] TYPE_RX16  = 8'h81;
    localparam logic [7:0] TYPE_RESP  = 8'h88;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    // Store write commands from the parser.
    typedef struct packed {
        logic                frame_we;
        logic [FRAME_AW-1:0] frame_addr;
        logic                resp_we;
        logic [RESP_AW-1:0]  resp_addr;
        logic [7:0]          data;
    } t_wr;

    // Status after the current request, ready for the output register.
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] frame_bytes;
        logic [4:0] response_bytes;
        logic       frame_held;
    } t_status;

endpackage

// ----- rtl/afr_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the frame store and the response store; no package dependency.
module afr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/afr_parser.sv -----
// Frame parser: phase, length, fill counts and checksum for both stores.
// Issues store writes and the status after each request. Uses afr_pkg.
module afr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_rx_byte,
    output afr_pkg::t_wr     o_wr,
    output afr_pkg::t_status o_status
);

    logic [2:0]                  r_phase,   n_phase;
    logic [15:0]                 r_len,     n_len;
    logic [afr_pkg::FILL_W-1:0]  r_fill,    n_fill;
    logic [afr_pkg::FILL_W-1:0]  r_target,  n_target;
    logic [7:0]                  r_sum,     n_sum;
    logic [afr_pkg::RFILL_W-1:0] r_rfill,   n_rfill;
    logic [afr_pkg::RFILL_W-1:0] r_rtarget, n_rtarget;
    logic [2:0]                  s_event;
    logic                        s_held_cur;
    logic                        s_held_next;
    logic                        s_is_data_type;

    // A checked frame is held when it is complete and no data frame is in progress.
    assign s_held_cur = (r_phase != afr_pkg::PH_DATA) && (r_fill != '0)
                        && (r_fill == r_target);
    assign s_is_data_type = (i_rx_byte == afr_pkg::TYPE_RX64)
                            || (i_rx_byte == afr_pkg::TYPE_RX16);

    // Next-state logic for one request.
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_fill    = r_fill;
        n_target  = r_target;
        n_sum     = r_sum;
        n_rfill   = r_rfill;
        n_rtarget = r_rtarget;
        s_event   = afr_pkg::EV_NONE;
        o_wr      = '0;
        o_wr.data = i_rx_byte;
        if (i_accept && (i_op == afr_pkg::OP_BYTE)) begin
            unique case (r_phase)
                afr_pkg::PH_IDLE: begin
                    if (i_rx_byte == afr_pkg::START_BYTE) begin
                        n_phase = afr_pkg::PH_LEN_HI;
                    end
                end
                afr_pkg::PH_LEN_HI: begin
                    n_len   = {i_rx_byte, 8'h00};
                    n_phase = afr_pkg::PH_LEN_LO;
                end
                afr_pkg::PH_LEN_LO: begin
                    n_len   = {r_len[15:8], i_rx_byte};
                    n_phase = afr_pkg::PH_TYPE;
                end
                afr_pkg::PH_TYPE: begin
                    if (s_is_data_type) begin
                        if (s_held_cur) begin
                            n_phase = afr_pkg::PH_IDLE;
                            s_event = afr_pkg::EV_BUSY;
                        end else if ({1'b0, r_len} >= 17'(afr_pkg::FRAME_DEPTH)) begin
                            n_phase = afr_pkg::PH_IDLE;
                            s_event = afr_pkg::EV_LONG;
                        end else begin
                            // The type byte is the first stored byte and starts the sum.
                            n_target        = afr_pkg::FILL_W'(r_len + 16'd1);
                            n_fill          = afr_pkg::FILL_W'(1);
                            n_sum           = i_rx_byte;
                            n_phase         = afr_pkg::PH_DATA;
                            o_wr.frame_we   = 1'b1;
                            o_wr.frame_addr = '0;
                            if (r_len == 16'd0) begin
                                // An empty frame completes at once and never sums to 0xFF.
                                n_phase = afr_pkg::PH_IDLE;
                                n_fill  = '0;
                                s_event = afr_pkg::EV_BADSUM;
                            end
                        end
                    end else if (i_rx_byte == afr_pkg::TYPE_RESP) begin
                        if ((r_len == 16'd0)
                            || (r_len > 16'(afr_pkg::RESPONSE_DEPTH))) begin
                            n_phase = afr_pkg::PH_IDLE;
                            s_event = afr_pkg::EV_LONG;
                        end else begin
                            n_rtarget = r_len[afr_pkg::RFILL_W-1:0];
                            n_rfill   = '0;
                            n_phase   = afr_pkg::PH_RESP;
                        end
                    end else begin
                        n_phase = afr_pkg::PH_IDLE;
                    end
                end
                afr_pkg::PH_RESP: begin
                    o_wr.resp_we   = 1'b1;
                    o_wr.resp_addr = r_rfill[afr_pkg::RESP_AW-1:0];
                    n_rfill        = r_rfill + 1'b1;
                    if (n_rfill >= r_rtarget) begin
                        n_phase = afr_pkg::PH_IDLE;
                        s_event = afr_pkg::EV_RESP;
                    end
                end
                afr_pkg::PH_DATA: begin
                    o_wr.frame_we   = 1'b1;
                    o_wr.frame_addr = r_fill[afr_pkg::FRAME_AW-1:0];
                    n_fill          = r_fill + 1'b1;
                    n_sum           = r_sum + i_rx_byte;
                    if (n_fill >= r_target) begin
                        n_phase = afr_pkg::PH_IDLE;
                        if (n_sum == afr_pkg::SUM_GOOD) begin
                            s_event = afr_pkg::EV_READY;
                        end else begin
                            n_fill  = '0;
                            s_event = afr_pkg::EV_BADSUM;
                        end
                    end
                end
                default: begin
                    n_phase = afr_pkg::PH_IDLE;
                end
            endcase
        end else if (i_accept && (i_op == afr_pkg::OP_RELEASE)) begin
            if (s_held_cur) begin
                n_fill = '0;
            end
        end
    end

    // Status as seen after this request.
    assign s_held_next = (n_phase != afr_pkg::PH_DATA) && (n_fill != '0)
                         && (n_fill == n_target);

    always_comb begin
        o_status.event_res      = s_event;
        o_status.frame_held     = s_held_next;
        o_status.frame_bytes    = s_held_next ? 8'(n_fill) : 8'd0;
        o_status.response_bytes = 5'd0;
        if ((n_phase != afr_pkg::PH_RESP) && (n_rfill != '0) && (n_rfill == n_rtarget)) begin
            o_status.response_bytes = 5'(n_rfill);
        end
    end

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= afr_pkg::PH_IDLE;
            r_len     <= '0;
            r_fill    <= '0;
            r_target  <= '0;
            r_sum     <= '0;
            r_rfill   <= '0;
            r_rtarget <= afr_pkg::RFILL_W'(1);
        end else begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_fill    <= n_fill;
            r_target  <= n_target;
            r_sum     <= n_sum;
            r_rfill   <= n_rfill;
            r_rtarget <= n_rtarget;
        end
    end

endmodule

// ----- rtl/api_frame_receiver.sv -----
// Top level of the API frame receiver: parser, frame store, response store
// and the output register. Uses afr_pkg, afr_parser and afr_ram.
//
// Usage: each input request carries an op. Op 0 feeds one received serial
// byte to the parser, op 1 reads the frame store at i_index, op 2 reads the
// response store at i_index, op 3 releases the held data frame. Every request
// gives exactly one result: an event code, the byte read (zero for ops 0 and
// 3 or an index past the store), the held frame size, the size of the last
// complete response and the held flag, all as they stand after the request.
// Results are registered: a request accepted in one cycle shows its result in
// the next one. Throughput is one request per cycle while results drain; the
// parser updates its state each cycle and both stores read and write in the
// same cycle through one write port and one registered read port each.
// The output register takes a new result whenever it is empty or being
// drained, so o_ready drops only while a result waits on a stalled receiver.
// Reset clears the parser to hunt for a start byte with no frame held and no
// response complete; store contents are undefined until written.
module api_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    input  logic [6:0] i_index,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_read_data,
    output logic [7:0] o_frame_bytes,
    output logic [4:0] o_response_bytes,
    output logic       o_frame_held
);

    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_FRAME = 2'd1;
    localparam logic [1:0] RD_RESP  = 2'd2;

    logic                           s_accept;
    afr_pkg::t_wr                   s_wr;
    afr_pkg::t_status               s_status;
    logic [7:0]                     s_frame_rdata;
    logic [7:0]                     s_resp_rdata;
    logic [1:0]                     s_rd_sel;
    logic                           r_valid;
    afr_pkg::t_status               r_status;
    logic [1:0]                     r_rd_sel;

    // A request is taken whenever the output register is free or draining.
    assign o_ready  = !r_valid || i_ready;
    assign s_accept = i_valid && o_ready;

    afr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (s_accept),
        .i_op      (i_op),
        .i_rx_byte (i_rx_byte),
        .o_wr      (s_wr),
        .o_status  (s_status)
    );

    afr_ram #(
        .DEPTH (afr_pkg::FRAME_DEPTH),
        .WIDTH (8)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (s_wr.frame_we),
        .i_waddr (s_wr.frame_addr),
        .i_wdata (s_wr.data),
        .i_re    (s_accept),
        .i_raddr (afr_pkg::FRAME_AW'(i_index)),
        .o_rdata (s_frame_rdata)
    );

    afr_ram #(
        .DEPTH (afr_pkg::RESPONSE_DEPTH),
        .WIDTH (8)
    ) u_resp_ram (
        .i_clk   (i_clk),
        .i_we    (s_wr.resp_we),
        .i_waddr (s_wr.resp_addr),
        .i_wdata (s_wr.data),
        .i_re    (s_accept),
        .i_raddr (afr_pkg::RESP_AW'(i_index)),
        .o_rdata (s_resp_rdata)
    );

    // Choose which store answers, with out-of-range indexes reading zero.
    always_comb begin
        s_rd_sel = RD_NONE;
        if ((i_op == afr_pkg::OP_RD_FRAME)
            && (32'(i_index) < 32'(afr_pkg::FRAME_DEPTH))) begin
            s_rd_sel = RD_FRAME;
        end else if ((i_op == afr_pkg::OP_RD_RESP)
                     && (32'(i_index) < 32'(afr_pkg::RESPONSE_DEPTH))) begin
            s_rd_sel = RD_RESP;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_status <= s_status;
            r_rd_sel <= s_rd_sel;
        end
    end

    // The store read data is held by the RAMs in step with the output register.
    always_comb begin
        unique case (r_rd_sel)
            RD_FRAME: o_read_data = s_frame_rdata;
            RD_RESP:  o_read_data = s_resp_rdata;
            default:  o_read_data = 8'd0;
        endcase
    end

    assign o_valid          = r_valid;
    assign o_event_res      = r_status.event_res;
    assign o_frame_bytes    = r_status.frame_bytes;
    assign o_response_bytes = r_status.response_bytes;
    assign o_frame_held     = r_status.frame_held;

endmodule

// ----- rtl/afr_checker.sv -----
// Port-level checks for the API frame receiver, attached by the bind below.
// Depends on afr_pkg for event codes and store sizes.
module afr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_event_res,
    input logic [7:0] o_frame_bytes,
    input logic [4:0] o_response_bytes,
    input logic       o_frame_held
);

    // The held flag and the held frame size agree.
    a_held_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_held == (o_frame_bytes != 8'd0)))
        else $error("frame_held disagrees with frame_bytes");

    // A frame that passes its checksum is held right away.
    a_ready_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_res == afr_pkg::EV_READY)) |-> o_frame_held)
        else $error("frame ready without a held frame");

    // A frame that fails its checksum leaves nothing held.
    a_bad_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_res == afr_pkg::EV_BADSUM)) |-> !o_frame_held)
        else $error("bad checksum left a frame held");

    // A complete response never exceeds its store.
    a_resp_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_response_bytes) <= 32'(afr_pkg::RESPONSE_DEPTH)))
        else $error("response size beyond the store");

    // A stalled result stays in place.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_event_res)
                                   && $stable(o_frame_bytes)))
        else $error("stalled result changed");

endmodule

bind api_frame_receiver afr_checker u_afr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_event_res      (o_event_res),
    .o_frame_bytes    (o_frame_bytes),
    .o_response_bytes (o_response_bytes),
    .o_frame_held     (o_frame_held)
);
